@@ rtl/clock_skew_ema_table_defines.svh @@
// assertion macros for the clock skew table rtl
`ifndef CLOCK_SKEW_EMA_TABLE_DEFINES_SVH
`define CLOCK_SKEW_EMA_TABLE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CSET_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CSET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cset_pkg.sv @@
// types, constants and codes of the clock skew table
package cset_pkg;

    localparam int NumClocksDef = 16;
    localparam int TimeW        = 64;
    localparam int SkewW        = 48;
    localparam int FracW        = 16;
    localparam int MxW          = 49;
    localparam int MyW          = 17;
    localparam int AccW         = MxW + MyW;
    localparam int IdxW         = 4;

    localparam logic [FracW-1:0] KeepWeight = 16'd52429;
    localparam logic [FracW-1:0] NewWeight  = 16'd13107;
    localparam logic [FracW-1:0] RoundBias  = 16'hFFFF;

    localparam logic CmdAdd   = 1'b0;
    localparam logic CmdQuery = 1'b1;

    typedef struct packed {
        logic                    command;
        logic [IdxW-1:0]         clock_index;
        logic signed [TimeW-1:0] rx_time;
        logic signed [TimeW-1:0] remote_time;
    } in_item_t;

    typedef struct packed {
        logic                    is_valid;
        logic signed [SkewW-1:0] skew;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_OWN,
        ST_RD_REF,
        ST_CHECK,
        ST_INST1,
        ST_INST2,
        ST_INST3,
        ST_MAC1,
        ST_MAC2,
        ST_MAC3,
        ST_WRITE,
        ST_QBIAS,
        ST_QOUT
    } state_t;

    typedef enum logic [1:0] {
        MODE_KEEP,
        MODE_CLEAR,
        MODE_UPDATE
    } mode_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MAC,
        ALU_MACS
    } alu_op_t;

    typedef enum logic [2:0] {
        SRC_TIMES,
        SRC_REF_RCV,
        SRC_REF_RMT,
        SRC_AHI,
        SRC_ALO,
        SRC_INST,
        SRC_QBIAS
    } alu_src_t;

    typedef struct packed {
        logic     in_ready;
        logic     rd_en;
        logic     rd_ref;
        logic     cap_own;
        logic     cap_inst;
        logic     alu_en;
        alu_op_t  alu_op;
        alu_src_t alu_src;
        logic     wr_en;
        logic     wr_avg;
        logic     wr_est;
        logic     out_load;
    } ctrl_t;

    typedef struct packed {
        logic is_query;
        logic idx_in_range;
        logic clear_cond;
        logic update_cond;
        logic out_busy;
    } stat_t;

endpackage

@@ rtl/cset_alu.sv @@
// shared add / subtract / multiply-accumulate unit with its accumulator
module cset_alu (
    input  logic                            clk,
    input  cset_pkg::ctrl_t                 ctrl,
    input  logic signed [cset_pkg::AccW-1:0] a,
    input  logic signed [cset_pkg::AccW-1:0] b,
    input  logic signed [cset_pkg::MxW-1:0]  mx,
    input  logic signed [cset_pkg::MyW-1:0]  my,
    output logic signed [cset_pkg::AccW-1:0] acc
);
    import cset_pkg::*;

    logic signed [AccW-1:0] prod;
    logic signed [AccW-1:0] addend;
    logic                   carry;
    logic signed [AccW-1:0] sum;
    logic signed [AccW-1:0] acc_reg;

    assign prod = mx * my;

    always_comb
    begin
        carry = 1'b0;
        case (ctrl.alu_op)
            ALU_ADD:  addend = b;
            ALU_SUB:
            begin
                addend = ~b;
                carry  = 1'b1;
            end
            ALU_MAC:  addend = prod;
            ALU_MACS: addend = prod >>> FracW;
            default:  addend = b;
        endcase
    end

    assign sum = a + addend + AccW'(carry);

    always_ff @(posedge clk)
    begin
        if (ctrl.alu_en)
        begin
            acc_reg <= sum;
        end
    end

    assign acc = acc_reg;

endmodule

@@ rtl/cset_table.sv @@
// per-clock table: time and average memories plus measured / estimate bits
module cset_table #(
    parameter int NUM_CLOCKS = cset_pkg::NumClocksDef
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cset_pkg::ctrl_t                   ctrl,
    input  logic [$clog2(NUM_CLOCKS)-1:0]     rd_addr,
    input  logic                              rd_in_range,
    input  logic [$clog2(NUM_CLOCKS)-1:0]     wr_addr,
    input  logic signed [cset_pkg::TimeW-1:0] wr_rcv,
    input  logic signed [cset_pkg::TimeW-1:0] wr_rmt,
    input  logic signed [cset_pkg::TimeW-1:0] wr_avg_data,
    output logic signed [cset_pkg::TimeW-1:0] rd_rcv,
    output logic signed [cset_pkg::TimeW-1:0] rd_rmt,
    output logic signed [cset_pkg::TimeW-1:0] rd_avg,
    output logic                              rd_meas,
    output logic                              rd_est
);
    import cset_pkg::*;

    logic signed [TimeW-1:0] rcv_mem [NUM_CLOCKS];
    logic signed [TimeW-1:0] rmt_mem [NUM_CLOCKS];
    logic signed [TimeW-1:0] avg_mem [NUM_CLOCKS];

    logic [NUM_CLOCKS-1:0] meas_reg;
    logic [NUM_CLOCKS-1:0] est_reg;

    logic signed [TimeW-1:0] rd_rcv_reg;
    logic signed [TimeW-1:0] rd_rmt_reg;
    logic signed [TimeW-1:0] rd_avg_reg;
    logic                    rd_meas_reg;
    logic                    rd_est_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            rcv_mem[wr_addr] <= wr_rcv;
            rmt_mem[wr_addr] <= wr_rmt;
        end
        if (ctrl.wr_avg)
        begin
            avg_mem[wr_addr] <= wr_avg_data;
        end
        if (ctrl.rd_en)
        begin
            rd_rcv_reg <= rcv_mem[rd_addr];
            rd_rmt_reg <= rmt_mem[rd_addr];
            rd_avg_reg <= avg_mem[rd_addr];
        end
    end

    // valid bits: an entry never written reads as cleared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_reg    <= '0;
            est_reg     <= '0;
            rd_meas_reg <= 1'b0;
            rd_est_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.wr_en)
            begin
                meas_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.wr_avg)
            begin
                est_reg[wr_addr] <= ctrl.wr_est;
            end
            if (ctrl.rd_en)
            begin
                rd_meas_reg <= rd_in_range ? meas_reg[rd_addr] : 1'b0;
                rd_est_reg  <= rd_in_range ? est_reg[rd_addr] : 1'b0;
            end
        end
    end

    assign rd_rcv  = rd_rcv_reg;
    assign rd_rmt  = rd_rmt_reg;
    assign rd_avg  = rd_avg_reg;
    assign rd_meas = rd_meas_reg;
    assign rd_est  = rd_est_reg;

endmodule

@@ rtl/cset_ctrl.sv @@
// sequencer driving table reads, the shared unit and the write-back
module cset_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_accept,
    input  cset_pkg::stat_t stat,
    output cset_pkg::ctrl_t ctrl
);
    import cset_pkg::*;

    state_t state_reg;
    state_t state_next;
    mode_t  mode_reg;
    mode_t  mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_KEEP;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_RD_OWN;
                end
            end
            ST_RD_OWN:
            begin
                if (stat.is_query)
                begin
                    state_next = ST_QBIAS;
                end
                else if (!stat.idx_in_range)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RD_REF;
                end
            end
            ST_RD_REF: state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (stat.clear_cond)
                begin
                    mode_next  = MODE_CLEAR;
                    state_next = ST_WRITE;
                end
                else if (stat.update_cond)
                begin
                    mode_next  = MODE_UPDATE;
                    state_next = ST_INST1;
                end
                else
                begin
                    mode_next  = MODE_KEEP;
                    state_next = ST_WRITE;
                end
            end
            ST_INST1:  state_next = ST_INST2;
            ST_INST2:  state_next = ST_INST3;
            ST_INST3:  state_next = ST_MAC1;
            ST_MAC1:   state_next = ST_MAC2;
            ST_MAC2:   state_next = ST_MAC3;
            ST_MAC3:   state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_IDLE;
            ST_QBIAS:  state_next = ST_QOUT;
            ST_QOUT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        ctrl.alu_op  = ALU_ADD;
        ctrl.alu_src = SRC_TIMES;
        case (state_reg)
            ST_IDLE:   ctrl.in_ready = 1'b1;
            ST_RD_OWN: ctrl.rd_en = 1'b1;
            ST_RD_REF:
            begin
                ctrl.rd_en   = 1'b1;
                ctrl.rd_ref  = 1'b1;
                ctrl.cap_own = 1'b1;
            end
            ST_CHECK:  ctrl.alu_en = 1'b0;
            ST_INST1:
            begin
                ctrl.alu_en  = 1'b1;
                ctrl.alu_op  = ALU_SUB;
                ctrl.alu_src = SRC_TIMES;
            end
            ST_INST2:
            begin
                ctrl.alu_en  = 1'b1;
                ctrl.alu_op  = ALU_ADD;
                ctrl.alu_src = SRC_REF_RCV;
            end
            ST_INST3:
            begin
                ctrl.alu_en  = 1'b1;
                ctrl.alu_op  = ALU_SUB;
                ctrl.alu_src = SRC_REF_RMT;
            end
            ST_MAC1:
            begin
                ctrl.alu_en   = 1'b1;
                ctrl.alu_op   = ALU_MAC;
                ctrl.alu_src  = SRC_AHI;
                ctrl.cap_inst = 1'b1;
            end
            ST_MAC2:
            begin
                ctrl.alu_en  = 1'b1;
                ctrl.alu_op  = ALU_MACS;
                ctrl.alu_src = SRC_ALO;
            end
            ST_MAC3:
            begin
                ctrl.alu_en  = 1'b1;
                ctrl.alu_op  = ALU_MAC;
                ctrl.alu_src = SRC_INST;
            end
            ST_WRITE:
            begin
                ctrl.wr_en  = 1'b1;
                ctrl.wr_avg = (mode_reg == MODE_UPDATE) || (mode_reg == MODE_CLEAR);
                ctrl.wr_est = (mode_reg == MODE_UPDATE);
            end
            ST_QBIAS:
            begin
                ctrl.alu_en  = 1'b1;
                ctrl.alu_op  = ALU_ADD;
                ctrl.alu_src = SRC_QBIAS;
            end
            ST_QOUT:   ctrl.out_load = !stat.out_busy;
            default:   ctrl.in_ready = 1'b0;
        endcase
    end

endmodule

@@ rtl/clock_skew_ema_table.sv @@
// top level of the clock skew moving-average table
//
// input channel (in_valid / in_stall / in_item): one transaction is either a
// measurement (command add) or a query. a measurement updates the addressed
// clock's stored times and, against the reference clock, its skew average;
// it produces no result. a query produces one result transaction on the
// output channel (out_valid / out_stall / out_item) with the valid flag and
// the skew in microseconds, truncated toward zero.
// config channel (cfg_valid / cfg_ready / cfg_data) writes the reference
// clock index; cfg_ready is always high, write only while idle.
// timing: in_stall is low only while the sequencer is idle. a query reads its
// own entry, biases the average and loads the result register; a measurement
// with a skew update reads its own, then the reference entry on the single
// table read port, forms the skew and walks the average update step by step
// on the one shared adder / multiplier, then writes; one that clears or keeps
// the estimate writes after the check, one past the table ends after its read.
// reset: all clocks unmeasured, no estimates, reference index 0; the
// valid bits clear at once so there is no clearing pass.
// a stalled result stays in the output register; the next item is still
// accepted, and a later query waits in its last step until the slot frees.
`include "clock_skew_ema_table_defines.svh"

module clock_skew_ema_table #(
    parameter int NUM_CLOCKS = cset_pkg::NumClocksDef
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  cset_pkg::in_item_t             in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output cset_pkg::out_item_t            out_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cset_pkg::IdxW-1:0]      cfg_data
);
    import cset_pkg::*;

    localparam int AddrW = $clog2(NUM_CLOCKS);

    // sequencer interface
    ctrl_t ctrl;
    stat_t stat;
    logic  in_accept;

    // captured transaction and reference register
    in_item_t        item_reg;
    logic [IdxW-1:0] ref_reg;

    // table read data
    logic signed [TimeW-1:0] rd_rcv;
    logic signed [TimeW-1:0] rd_rmt;
    logic signed [TimeW-1:0] rd_avg;
    logic                    rd_meas;
    logic                    rd_est;
    logic signed [TimeW-1:0] rd_avg_m;

    // own entry as read before the reference entry replaces the read data
    logic signed [TimeW-1:0] own_rcv_reg;
    logic signed [TimeW-1:0] own_rmt_reg;
    logic signed [TimeW-1:0] own_avg_reg;
    logic                    own_meas_reg;

    // saturated instantaneous skew
    logic signed [SkewW-1:0] inst_reg;
    logic signed [SkewW-1:0] inst_next;
    logic                    inst_fits;

    // shared unit operands
    logic signed [AccW-1:0] alu_a;
    logic signed [AccW-1:0] alu_b;
    logic signed [MxW-1:0]  alu_mx;
    logic signed [MyW-1:0]  alu_my;
    logic signed [AccW-1:0] acc;

    logic             idx_in_range;
    logic             ref_in_range;
    logic [AddrW-1:0] idx_addr;
    logic [AddrW-1:0] ref_addr;
    logic [AddrW-1:0] rd_addr;
    logic             rd_in_range;
    logic             lt_rcv;
    logic             lt_rmt;
    logic             oob_meas_read;

    logic      out_valid_reg;
    out_item_t out_item_reg;

    assign in_stall  = !ctrl.in_ready;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ref_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg <= in_item;
        end
    end

    // index decoding, entries past the table are never touched
    assign idx_in_range = int'(item_reg.clock_index) < NUM_CLOCKS;
    assign ref_in_range = int'(ref_reg) < NUM_CLOCKS;
    assign idx_addr     = AddrW'(item_reg.clock_index);
    assign ref_addr     = AddrW'(ref_reg);
    assign rd_addr      = ctrl.rd_ref ? ref_addr : idx_addr;
    assign rd_in_range  = ctrl.rd_ref ? ref_in_range : idx_in_range;

    cset_table #(
        .NUM_CLOCKS (NUM_CLOCKS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .rd_addr     (rd_addr),
        .rd_in_range (rd_in_range),
        .wr_addr     (idx_addr),
        .wr_rcv      (item_reg.rx_time),
        .wr_rmt      (item_reg.remote_time),
        .wr_avg_data (acc[TimeW-1:0]),
        .rd_rcv      (rd_rcv),
        .rd_rmt      (rd_rmt),
        .rd_avg      (rd_avg),
        .rd_meas     (rd_meas),
        .rd_est      (rd_est)
    );

    // an average without an estimate is zero
    assign rd_avg_m = rd_est ? rd_avg : '0;

    always_ff @(posedge clk)
    begin
        if (ctrl.cap_own)
        begin
            own_rcv_reg <= rd_rcv;
            own_rmt_reg <= rd_rmt;
            own_avg_reg <= rd_avg_m;
        end
        if (ctrl.cap_inst)
        begin
            inst_reg <= inst_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_meas_reg <= 1'b0;
        end
        else if (ctrl.cap_own)
        begin
            own_meas_reg <= rd_meas;
        end
    end

    // backwards-time check against the clock's own last times
    assign lt_rcv = item_reg.rx_time < own_rcv_reg;
    assign lt_rmt = item_reg.remote_time < own_rmt_reg;

    // saturate the exact skew to 48 bits
    assign inst_fits = (acc[AccW-1:SkewW-1] == '0) || (acc[AccW-1:SkewW-1] == '1);
    assign inst_next = inst_fits ? acc[SkewW-1:0]
                     : (acc[AccW-1] ? {1'b1, {(SkewW-1){1'b0}}}
                                    : {1'b0, {(SkewW-1){1'b1}}});

    assign stat.is_query     = (item_reg.command == CmdQuery);
    assign stat.idx_in_range = idx_in_range;
    assign stat.clear_cond   = !own_meas_reg || lt_rcv || lt_rmt;
    assign stat.update_cond  = (item_reg.clock_index != ref_reg) && rd_meas;
    assign stat.out_busy     = out_valid_reg && out_stall;

    // operand selection per step:
    // skew = (rmt - rcv) + ref_rcv - ref_rmt
    // avg' = ahi * keep + (alo * keep) >> 16 + inst * new
    always_comb
    begin
        alu_a  = acc;
        alu_b  = '0;
        alu_mx = '0;
        alu_my = '0;
        case (ctrl.alu_src)
            SRC_TIMES:
            begin
                alu_a = AccW'(item_reg.remote_time);
                alu_b = AccW'(item_reg.rx_time);
            end
            SRC_REF_RCV: alu_b = AccW'(rd_rcv);
            SRC_REF_RMT: alu_b = AccW'(rd_rmt);
            SRC_AHI:
            begin
                // integer part of the average, sign carried into the multiplier
                alu_a  = '0;
                alu_mx = MxW'($signed(own_avg_reg[TimeW-1:FracW]));
                alu_my = MyW'(KeepWeight);
            end
            SRC_ALO:
            begin
                alu_mx = {{(MxW-FracW){1'b0}}, own_avg_reg[FracW-1:0]};
                alu_my = MyW'(KeepWeight);
            end
            SRC_INST:
            begin
                alu_mx = MxW'(inst_reg);
                alu_my = MyW'(NewWeight);
            end
            SRC_QBIAS:
            begin
                // bias negative values so the shift truncates toward zero
                alu_a = AccW'(rd_avg_m);
                alu_b = rd_avg_m[TimeW-1] ? AccW'(RoundBias) : '0;
            end
            default:
            begin
                alu_a = acc;
            end
        endcase
    end

    cset_alu u_alu (
        .clk  (clk),
        .ctrl (ctrl),
        .a    (alu_a),
        .b    (alu_b),
        .mx   (alu_mx),
        .my   (alu_my),
        .acc  (acc)
    );

    cset_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // result register, holds while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_item_reg.is_valid <= rd_est;
            out_item_reg.skew     <= acc[TimeW-1:FracW];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // first read of a measurement for a clock past the table
    assign oob_meas_read = ctrl.rd_en && !ctrl.rd_ref && !stat.is_query && !idx_in_range;

    `CSET_ASSERT_NEXT(a_load_raises_valid, ctrl.out_load, out_valid, "result load lost")
    `CSET_ASSERT_IMPL(a_write_while_busy, ctrl.wr_en, in_stall, "table written while idle")
    `CSET_ASSERT_IMPL(a_load_on_query, ctrl.out_load, stat.is_query, "result from a measurement")
    `CSET_ASSERT_NEXT(a_oob_meas_dropped, oob_meas_read, !in_stall, "oob measurement not dropped")

endmodule
